// ===== hdl/block_matrix_multiply_subtract_top_assert.svh =====
`ifndef BLOCK_MATRIX_MULTIPLY_SUBTRACT_TOP_ASSERT_SVH
`define BLOCK_MATRIX_MULTIPLY_SUBTRACT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define BMMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmms assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define BMMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmms assertion failed");

`endif

// ===== hdl/bmms_pkg.sv =====
package bmms_pkg;

   // Field widths
   localparam int FP_W       = 64;
   localparam int CFG_W      = 3;
   localparam int RIDX_W     = 4;
   localparam int MAX_DIM_DEF = 4;
   localparam logic [CFG_W-1:0] DIM_RESET = 3'd3;

   // binary64 constants
   localparam logic [FP_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [FP_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

   typedef struct packed {
      logic            func;
      logic [FP_W-1:0] elem_a;
      logic [FP_W-1:0] elem_b;
      logic [FP_W-1:0] elem_c;
      logic            last_elem;
   } req_type;

   typedef struct packed {
      logic [FP_W-1:0]   result_value;
      logic [RIDX_W-1:0] result_index;
      logic              result_last;
      logic              count_error;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2
   } fpu_op_type;

   typedef struct packed {
      logic            start;
      fpu_op_type      op;
      logic [FP_W-1:0] opnd_a;
      logic [FP_W-1:0] opnd_b;
   } fpu_req_type;

   typedef struct packed {
      logic            done;
      logic [FP_W-1:0] result;
   } fpu_rsp_type;

endpackage

// ===== hdl/block_matrix_multiply_subtract_top.sv =====
// Square block multiply (B*C) or multiply-subtract (A - B*C) on IEEE binary64,
// every product and sum rounded to nearest even. A load takes one request per
// cycle while req_stall is low, carrying one element of A, B and C in row-major
// order; the mode is taken from the first request and the load ends at the
// request with last_elem set. The size comes from the block_dim register (0 reads
// as 1, values above MAX_DIM as MAX_DIM). If the load count differs from the size
// squared, one error result is sent. Otherwise dim*dim results follow in row-major
// order. All arithmetic goes through one shared multi-cycle floating-point unit;
// special operands, and a zero operand of a multiply, go straight from operand
// set-up to done. Each result takes dim multiplies and dim adds, plus a subtract
// in multiply-subtract mode, and no request is taken from the end of a load until
// the last result has entered the output register.
module block_matrix_multiply_subtract_top #(
   parameter int MAX_DIM = bmms_pkg::MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bmms_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bmms_pkg::rsp_type            rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [bmms_pkg::CFG_W-1:0]   csr_wr_data
);
   import bmms_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 2);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CTR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(DEPTH + 1);

   typedef enum logic [9:0] {
      S_LOAD = 10'b00_0000_0001,
      S_READ = 10'b00_0000_0010,
      S_MUL  = 10'b00_0000_0100,
      S_MULW = 10'b00_0000_1000,
      S_ADD  = 10'b00_0001_0000,
      S_ADDW = 10'b00_0010_0000,
      S_SUB  = 10'b00_0100_0000,
      S_SUBW = 10'b00_1000_0000,
      S_EMIT = 10'b01_0000_0000,
      S_ERR  = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   block_dim_ff;
   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic               mode_ff, mode_in;
   logic [CTR_W-1:0]   row_ff, row_in, col_ff, col_in, k_ff, k_in;
   logic [FP_W-1:0]    acc_ff, acc_in, prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [FP_W-1:0]    store_a [DEPTH];
   logic [FP_W-1:0]    store_b [DEPTH];
   logic [FP_W-1:0]    store_c [DEPTH];
   logic [FP_W-1:0]    rd_a_ff, rd_b_ff, rd_c_ff;

   logic [DIM_W-1:0]   dim;
   logic [3:0]         dim_raw;
   logic [CNT_W-1:0]   n_elems, total, pos, addr_b, addr_c;
   logic               req_acc, out_free, mem_we, k_last, pos_last;
   fpu_req_type        fpu_req;
   fpu_rsp_type        fpu_rsp;

   // Effective block size
   always_comb begin
      dim_raw = {1'b0, block_dim_ff};
      if (dim_raw == 4'd0) begin
         dim = DIM_W'(1);
      end else if (dim_raw > 4'(MAX_DIM)) begin
         dim = DIM_W'(MAX_DIM);
      end else begin
         dim = DIM_W'(dim_raw);
      end
   end

   assign n_elems  = CNT_W'(dim) * CNT_W'(dim);
   assign total    = (load_count_ff == CNT_SAT) ? CNT_SAT : load_count_ff + CNT_W'(1);
   assign req_stall = (state_ff != S_LOAD);
   assign req_acc  = req_valid && !req_stall;
   assign mem_we   = req_acc && (load_count_ff < CNT_W'(DEPTH));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Element addresses for the current dot-product step
   assign pos      = CNT_W'(row_ff) * CNT_W'(dim) + CNT_W'(col_ff);
   assign addr_b   = CNT_W'(row_ff) * CNT_W'(dim) + CNT_W'(k_ff);
   assign addr_c   = CNT_W'(k_ff) * CNT_W'(dim) + CNT_W'(col_ff);
   assign k_last   = (DIM_W'(k_ff) + DIM_W'(1)) == dim;
   assign pos_last = (pos + CNT_W'(1)) == n_elems;

   // Element stores: one write port for loading, registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_a[load_count_ff[IDX_W-1:0]] <= req_payload.elem_a;
         store_b[load_count_ff[IDX_W-1:0]] <= req_payload.elem_b;
         store_c[load_count_ff[IDX_W-1:0]] <= req_payload.elem_c;
      end
      rd_a_ff <= store_a[pos[IDX_W-1:0]];
      rd_b_ff <= store_b[addr_b[IDX_W-1:0]];
      rd_c_ff <= store_c[addr_c[IDX_W-1:0]];
   end

   // Operation issued to the arithmetic unit
   always_comb begin
      fpu_req.start  = (state_ff == S_MUL) || (state_ff == S_ADD) || (state_ff == S_SUB);
      fpu_req.op     = OP_MUL;
      fpu_req.opnd_a = rd_b_ff;
      fpu_req.opnd_b = rd_c_ff;
      if (state_ff == S_ADD) begin
         fpu_req.op     = OP_ADD;
         fpu_req.opnd_a = acc_ff;
         fpu_req.opnd_b = prod_ff;
      end else if (state_ff == S_SUB) begin
         fpu_req.op     = OP_SUB;
         fpu_req.opnd_a = rd_a_ff;
         fpu_req.opnd_b = acc_ff;
      end
   end

   bmms_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   // Load and compute sequencer
   always_comb begin
      state_in       = state_ff;
      load_count_in  = load_count_ff;
      mode_in        = mode_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      k_in           = k_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (load_count_ff == '0) mode_in = req_payload.func;
               load_count_in = total;
               if (req_payload.last_elem) begin
                  load_count_in = '0;
                  row_in = '0;
                  col_in = '0;
                  k_in   = '0;
                  acc_in = '0;
                  if (total != n_elems) begin
                     mode_in  = 1'b0;
                     state_in = S_ERR;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: state_in = S_MUL;
         S_MUL:  state_in = S_MULW;
         S_MULW: begin
            if (fpu_rsp.done) begin
               prod_in  = fpu_rsp.result;
               state_in = S_ADD;
            end
         end
         S_ADD:  state_in = S_ADDW;
         S_ADDW: begin
            if (fpu_rsp.done) begin
               acc_in = fpu_rsp.result;
               if (!k_last) begin
                  k_in     = k_ff + CTR_W'(1);
                  state_in = S_READ;
               end else if (mode_ff) begin
                  state_in = S_SUB;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_SUB:  state_in = S_SUBW;
         S_SUBW: begin
            if (fpu_rsp.done) begin
               acc_in   = fpu_rsp.result;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.result_value = acc_ff;
               rsp_payload_in.result_index = RIDX_W'(pos);
               rsp_payload_in.result_last  = pos_last;
               rsp_payload_in.count_error  = 1'b0;
               acc_in = '0;
               k_in   = '0;
               if (pos_last) begin
                  mode_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_READ;
                  if (DIM_W'(col_ff) + DIM_W'(1) == dim) begin
                     col_in = '0;
                     row_in = row_ff + CTR_W'(1);
                  end else begin
                     col_in = col_ff + CTR_W'(1);
                  end
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.result_value = '0;
               rsp_payload_in.result_index = '0;
               rsp_payload_in.result_last  = 1'b1;
               rsp_payload_in.count_error  = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         block_dim_ff  <= DIM_RESET;
         load_count_ff <= '0;
         mode_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) block_dim_ff <= csr_wr_data;
         load_count_ff <= load_count_in;
         mode_ff       <= mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      row_ff         <= row_in;
      col_ff         <= col_in;
      k_ff           <= k_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/bmms_fpu.sv =====
module bmms_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  bmms_pkg::fpu_req_type fpu_req,
   output bmms_pkg::fpu_rsp_type fpu_rsp
);
   import bmms_pkg::*;

   // Working mantissa: bit 107 is the leading one of a normal result
   localparam int WN = 108;
   localparam int HALF = 27;
   localparam logic [2:0] MUL_LAST = 3'd4;

   typedef enum logic [7:0] {
      F_IDLE  = 8'b0000_0001,
      F_PREP  = 8'b0000_0010,
      F_MUL   = 8'b0000_0100,
      F_ADDC  = 8'b0000_1000,
      F_RSH   = 8'b0001_0000,
      F_NORM  = 8'b0010_0000,
      F_ROUND = 8'b0100_0000,
      F_DONE  = 8'b1000_0000
   } fstate_type;

   fstate_type      state_ff, state_in;
   fpu_op_type      op_ff, op_in;
   logic [FP_W-1:0] a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [WN-1:0]   w_ff, w_in, wl_ff, wl_in, ws_ff, ws_in;
   logic signed [13:0] x_ff, x_in;
   logic            sign_ff, sign_in, zsign_ff, zsign_in, sub_ff, sub_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [53:0]     pp_ff, pp_in;
   logic [1:0]      ppsel_ff, ppsel_in;

   // Operand decode
   logic [10:0] ea, eb, eaa, ebb;
   logic [52:0] ma, mb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, a_big;
   logic [26:0] mx, my;
   logic [3:0]  lz;

   function automatic logic [WN-1:0] shr_sticky(input logic [WN-1:0] v,
                                                input logic [11:0] amt);
      logic [WN-1:0] sh;
      logic          lost;
      if (amt >= 12'(WN)) begin
         shr_sticky = {{(WN-1){1'b0}}, |v};
      end else begin
         sh   = v >> amt[6:0];
         lost = |(v & ~({WN{1'b1}} << amt[6:0]));
         shr_sticky = {sh[WN-1:1], sh[0] | lost};
      end
   endfunction

   always_comb begin
      ea     = a_ff[62:52];
      eb     = b_ff[62:52];
      eaa    = (|ea) ? ea : 11'd1;
      ebb    = (|eb) ? eb : 11'd1;
      ma     = {|ea, a_ff[51:0]};
      mb     = {|eb, b_ff[51:0]};
      a_nan  = (&ea) && (|a_ff[51:0]);
      b_nan  = (&eb) && (|b_ff[51:0]);
      a_inf  = (&ea) && !(|a_ff[51:0]);
      b_inf  = (&eb) && !(|b_ff[51:0]);
      a_zero = !(|a_ff[62:0]);
      b_zero = !(|b_ff[62:0]);
      sbe    = b_ff[63] ^ (op_ff == OP_SUB);
      a_big  = a_ff[62:0] >= b_ff[62:0];
   end

   // Partial product operands, 27-bit halves of each mantissa
   always_comb begin
      unique case (cnt_ff)
         3'd0:    begin mx = ma[26:0];          my = mb[26:0];          end
         3'd1:    begin mx = ma[26:0];          my = {1'b0, mb[52:27]}; end
         3'd2:    begin mx = {1'b0, ma[52:27]}; my = mb[26:0];          end
         default: begin mx = {1'b0, ma[52:27]}; my = {1'b0, mb[52:27]}; end
      endcase
   end

   // Leading zeros in the top byte of the working mantissa
   always_comb begin
      lz = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (w_ff[WN-8+i]) lz = 4'(7 - i);
      end
   end

   always_comb begin
      logic [53:0]   m54;
      logic [52:0]   mf;
      logic signed [13:0] xr;
      logic          inc;
      logic [13:0]   xm1;
      logic [3:0]    n;
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      w_in     = w_ff;
      wl_in    = wl_ff;
      ws_in    = ws_ff;
      x_in     = x_ff;
      sign_in  = sign_ff;
      zsign_in = zsign_ff;
      sub_in   = sub_ff;
      cnt_in   = cnt_ff;
      pp_in    = mx * my;
      ppsel_in = (cnt_ff == 3'd0) ? 2'd0 : ((cnt_ff == 3'd3) ? 2'd2 : 2'd1);
      m54 = '0;
      mf  = '0;
      xr  = '0;
      inc = 1'b0;
      xm1 = '0;
      n   = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (fpu_req.start) begin
               op_in    = fpu_req.op;
               a_in     = fpu_req.opnd_a;
               b_in     = fpu_req.opnd_b;
               state_in = F_PREP;
            end
         end
         // Special operands, exponent and alignment set-up
         F_PREP: begin
            state_in = F_DONE;
            if (a_nan) begin
               res_in = a_ff | QUIET_BIT;
            end else if (b_nan) begin
               res_in = b_ff | QUIET_BIT;
            end else if (op_ff == OP_MUL) begin
               if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                  res_in = DEFAULT_NAN;
               end else if (a_inf || b_inf) begin
                  res_in = {a_ff[63] ^ b_ff[63], 11'h7FF, 52'd0};
               end else if (a_zero || b_zero) begin
                  res_in = {a_ff[63] ^ b_ff[63], 63'd0};
               end else begin
                  x_in     = 14'(eaa) + 14'(ebb) - 14'd1020;
                  w_in     = '0;
                  cnt_in   = '0;
                  sign_in  = a_ff[63] ^ b_ff[63];
                  state_in = F_MUL;
               end
            end else begin
               if (a_inf && b_inf) begin
                  res_in = (a_ff[63] != sbe) ? DEFAULT_NAN : a_ff;
               end else if (a_inf) begin
                  res_in = a_ff;
               end else if (b_inf) begin
                  res_in = {sbe, 11'h7FF, 52'd0};
               end else begin
                  sub_in   = a_ff[63] ^ sbe;
                  zsign_in = a_ff[63] & sbe;
                  if (a_big) begin
                     sign_in = a_ff[63];
                     x_in    = 14'(eaa) + 14'd1;
                     wl_in   = {1'b0, ma, 54'd0};
                     ws_in   = shr_sticky({1'b0, mb, 54'd0}, 12'(eaa - ebb));
                  end else begin
                     sign_in = sbe;
                     x_in    = 14'(ebb) + 14'd1;
                     wl_in   = {1'b0, mb, 54'd0};
                     ws_in   = shr_sticky({1'b0, ma, 54'd0}, 12'(ebb - eaa));
                  end
                  state_in = F_ADDC;
               end
            end
         end
         // Four partial products, each accumulated in the cycle after the multiplier forms it
         F_MUL: begin
            if (cnt_ff != 3'd0) begin
               unique case (ppsel_ff)
                  2'd0:    w_in = w_ff + {54'd0, pp_ff};
                  2'd1:    w_in = w_ff + ({54'd0, pp_ff} << HALF);
                  default: w_in = w_ff + ({54'd0, pp_ff} << (2 * HALF));
               endcase
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == MUL_LAST) state_in = F_RSH;
         end
         F_ADDC: begin
            w_in     = sub_ff ? (wl_ff - ws_ff) : (wl_ff + ws_ff);
            state_in = F_RSH;
         end
         // Zero result, or denormalise into the subnormal range
         F_RSH: begin
            if (!(|w_ff)) begin
               res_in   = {zsign_ff, 63'd0};
               state_in = F_DONE;
            end else begin
               if (x_ff < 14'sd1) begin
                  w_in = shr_sticky(w_ff, 12'(14'sd1 - x_ff));
                  x_in = 14'sd1;
               end
               state_in = F_NORM;
            end
         end
         // Left normalise up to eight places a cycle, never below exponent 1
         F_NORM: begin
            if (w_ff[WN-1] || (x_ff == 14'sd1)) begin
               state_in = F_ROUND;
            end else begin
               xm1 = 14'(x_ff - 14'sd1);
               n   = (xm1 < {10'd0, lz}) ? xm1[3:0] : lz;
               w_in = w_ff << n;
               x_in = x_ff - 14'(n);
            end
         end
         // Round to nearest even and pack
         F_ROUND: begin
            inc = w_ff[54] & ((|w_ff[53:0]) | w_ff[55]);
            m54 = {1'b0, w_ff[WN-1:55]} + 54'(inc);
            if (m54[53]) begin
               mf = m54[53:1];
               xr = x_ff + 14'sd1;
            end else begin
               mf = m54[52:0];
               xr = x_ff;
            end
            if (xr > 14'sd2046) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sign_ff, mf[52] ? xr[10:0] : 11'd0, mf[51:0]};
            end
            state_in = F_DONE;
         end
         F_DONE: state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      w_ff     <= w_in;
      wl_ff    <= wl_in;
      ws_ff    <= ws_in;
      x_ff     <= x_in;
      sign_ff  <= sign_in;
      zsign_ff <= zsign_in;
      sub_ff   <= sub_in;
      cnt_ff   <= cnt_in;
      pp_ff    <= pp_in;
      ppsel_ff <= ppsel_in;
   end

   assign fpu_rsp.done   = (state_ff == F_DONE);
   assign fpu_rsp.result = res_ff;

endmodule

// ===== hdl/bmms_checker.sv =====
`include "block_matrix_multiply_subtract_top_assert.svh"

module bmms_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input bmms_pkg::req_type          req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input bmms_pkg::rsp_type          rsp_payload,
   input logic                       csr_wr_en,
   input logic [bmms_pkg::CFG_W-1:0] csr_wr_data
);
   import bmms_pkg::*;

   // Held result must not change while stalled
`BMMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // An error result is a lone, zeroed, final result
`BMMS_ASSERT_NOW(a_err_form, clock, reset, rsp_valid && rsp_payload.count_error, rsp_payload.result_last && (rsp_payload.result_value == '0) && (rsp_payload.result_index == '0))

   // The end of a load always makes the block busy
`BMMS_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && !req_stall && req_payload.last_elem, req_stall)

   // No result straight out of reset
`BMMS_ASSERT_NOW(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind block_matrix_multiply_subtract_top bmms_checker u_bmms_checker (.*);
